// File: design/rtq_pkg.sv
// ----------------------------------------------------------------------------
// Retransmit timer queue package
// Shared constants, request and result codes, state and result types.
// ----------------------------------------------------------------------------
package rtq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int TIME_BITS   = 32;
	localparam int MAX_RESULTS = 16;
	localparam int SLOT_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
	localparam int BUD_BITS    = $clog2(MAX_RESULTS + 1);

	typedef logic [SLOT_BITS-1:0] slot_idx_t;
	typedef logic [CNT_BITS-1:0]  count_t;
	typedef logic [TIME_BITS-1:0] time_t;

	typedef enum logic [1:0] {
		REQ_ADD  = 2'd0,
		REQ_ACK  = 2'd1,
		REQ_TICK = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		KIND_ADDED   = 3'd0,
		KIND_FULL    = 3'd1,
		KIND_REMOVED = 3'd2,
		KIND_RESEND  = 3'd3,
		KIND_GIVE_UP = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACK_SCAN,
		ST_UNLINK,
		ST_TICK_HEAD,
		ST_TICK_DECIDE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  ack_id;
		logic [15:0] buffer_handle;
		logic [15:0] payload_size;
		logic [15:0] resend_interval;
		logic [7:0]  retry_budget;
		logic [7:0]  conn_handle;
	} req_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  entry_id;
		logic [15:0] out_buffer;
		logic [15:0] out_size;
		logic [7:0]  out_conn;
		logic        found;
		logic        last;
	} res_item_t;

	typedef struct packed {
		logic [7:0]  id;
		logic [15:0] buffer;
		logic [15:0] size;
		time_t       deadline;
		logic [15:0] interval;
		logic [7:0]  retries;
		logic [7:0]  conn;
	} slot_t;

endpackage

// File: design/rtq_if.sv
// ----------------------------------------------------------------------------
// Retransmit timer queue channel interfaces
// Valid/ready channels for request and result transactions.
// ----------------------------------------------------------------------------
interface rtq_req_if;
	import rtq_pkg::*;
	logic      valid;
	logic      ready;
	req_item_t data;
	modport source  (output valid, output data, input ready);
	modport sink    (input valid, input data, output ready);
	modport monitor (input valid, input data, input ready);
endinterface

interface rtq_res_if;
	import rtq_pkg::*;
	logic      valid;
	logic      ready;
	res_item_t data;
	modport source  (output valid, output data, input ready);
	modport sink    (input valid, input data, output ready);
	modport monitor (input valid, input data, input ready);
endinterface

// File: design/rtq_slot_ram.sv
// ----------------------------------------------------------------------------
// Retransmit timer queue slot store
// One write port and one registered read port over the packet slots.
// ----------------------------------------------------------------------------
module rtq_slot_ram (
	input  logic              clk,
	input  logic              we,
	input  rtq_pkg::slot_idx_t waddr,
	input  rtq_pkg::slot_t    wdata,
	input  rtq_pkg::slot_idx_t raddr,
	output rtq_pkg::slot_t    rdata
);
	import rtq_pkg::*;

	slot_t mem [QUEUE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/rtq_order_list.sv
// ----------------------------------------------------------------------------
// Retransmit timer queue order list
// Slot numbers in insertion order with append, and one-position-per-cycle
// removal by shifting, plus a free slot bitmap.
// ----------------------------------------------------------------------------
module rtq_order_list (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rtq_pkg::slot_idx_t push_slot,
	input  logic               pop_start,
	input  rtq_pkg::count_t    pop_pos,
	input  logic               free_slot_en,
	input  rtq_pkg::slot_idx_t rd_pos,
	output rtq_pkg::slot_idx_t rd_slot,
	output rtq_pkg::count_t    count,
	output rtq_pkg::slot_idx_t free_slot,
	output logic               busy
);
	import rtq_pkg::*;

	slot_idx_t               list_q [QUEUE_DEPTH];
	count_t                  count_q;
	logic [QUEUE_DEPTH-1:0]  used_q;
	logic                    busy_q;
	count_t                  pos_q;

	assign count   = count_q;
	assign busy    = busy_q;
	assign rd_slot = list_q[rd_pos];

	always_comb begin
		free_slot = '0;
		for (int s = QUEUE_DEPTH - 1; s >= 0; s--) begin
			if (!used_q[s]) begin
				free_slot = slot_idx_t'(s);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			used_q  <= '0;
			busy_q  <= 1'b0;
			pos_q   <= '0;
		end else begin
			if (pop_start) begin
				busy_q <= 1'b1;
				pos_q  <= pop_pos;
				if (free_slot_en) begin
					used_q[list_q[pop_pos[SLOT_BITS-1:0]]] <= 1'b0;
				end
			end else if (busy_q) begin
				if (pos_q + count_t'(1) >= count_q) begin
					busy_q  <= 1'b0;
					count_q <= count_q - count_t'(1);
				end else begin
					list_q[pos_q[SLOT_BITS-1:0]] <= list_q[SLOT_BITS'(pos_q + count_t'(1))];
					pos_q <= pos_q + count_t'(1);
				end
			end else if (push) begin
				list_q[count_q[SLOT_BITS-1:0]] <= push_slot;
				used_q[push_slot]              <= 1'b1;
				count_q                        <= count_q + count_t'(1);
			end
		end
	end

endmodule

// File: design/retransmit_timer_queue.sv
// ----------------------------------------------------------------------------
// Retransmit timer queue
// Holds packets awaiting acknowledgement in insertion order, resends or gives
// up on expired heads at each millisecond tick.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel and results leave on the res channel,
// each a valid/ready transaction. The block takes one request at a time and
// drops ready until every result of that request has been taken.
// An add gives its one result in the cycle after it is accepted.
// An acknowledge scans the order list one entry at a time through the
// slot store read port, then closes the gap one position a cycle.
// A tick handles up to sixteen heads; a tick that finds nothing expired
// gives no result and frees the input. The single slot store port and the
// shifting order list set the pace of both. The last result of each request
// carries last.
// After reset the queue is empty, the first id is one and the clock is zero.
// A stalled receiver holds the block in its result state; the result stays
// stable until taken and nothing else advances.
// ----------------------------------------------------------------------------
module retransmit_timer_queue (
	input logic   clk,
	input logic   arst_n,
	rtq_req_if.sink   req,
	rtq_res_if.source res
);
	import rtq_pkg::*;

	state_t    state_q, state_d;
	req_item_t item_q;
	time_t     now_q;
	logic [7:0] next_id_q;
	count_t    pos_q;
	logic [BUD_BITS-1:0] budget_q;
	res_item_t res_q;
	logic      res_valid_q;
	logic      res_held_q;
	logic      after_unlink_q;
	logic      requeue_q;
	slot_idx_t cur_slot_q;

	logic      ram_we;
	slot_idx_t ram_waddr, ram_raddr;
	slot_t     ram_wdata, ram_rdata;

	logic      push, pop_start, free_en;
	slot_idx_t push_slot, rd_slot, free_slot, rd_pos;
	count_t    count;
	logic      list_busy;
	time_t     diff;
	logic      req_take;
	logic      res_set;
	logic      scan_wait;
	logic      tick_stop;

	rtq_slot_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rtq_order_list u_list (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.push_slot    (push_slot),
		.pop_start    (pop_start),
		.pop_pos      (pos_q),
		.free_slot_en (free_en),
		.rd_pos       (rd_pos),
		.rd_slot      (rd_slot),
		.count        (count),
		.free_slot    (free_slot),
		.busy         (list_busy)
	);

	assign req.ready = (state_q == ST_IDLE) && !res_valid_q;
	assign res.valid = res_valid_q;
	assign res.data  = res_q;
	assign diff      = now_q - ram_rdata.deadline;
	assign req_take  = req.valid && req.ready;
	assign tick_stop = (budget_q == '0) || (count == '0) || diff[TIME_BITS-1];

	always_comb begin
		rd_pos = pos_q[SLOT_BITS-1:0];
		if (state_q == ST_IDLE || state_q == ST_TICK_HEAD) begin
			rd_pos = '0;
		end
	end
	assign ram_raddr = rd_slot;

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = free_slot;
		ram_wdata = ram_rdata;
		push      = 1'b0;
		push_slot = free_slot;
		pop_start = 1'b0;
		free_en   = 1'b0;
		res_set   = 1'b0;
		scan_wait = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_take) begin
					unique case (req_t'(req.data.req_type))
						REQ_ADD: begin
							res_set = 1'b1;
							if (count < count_t'(QUEUE_DEPTH)) begin
								ram_we             = 1'b1;
								ram_wdata.id       = next_id_q;
								ram_wdata.buffer   = req.data.buffer_handle;
								ram_wdata.size     = req.data.payload_size;
								ram_wdata.interval = req.data.resend_interval;
								ram_wdata.deadline = now_q + time_t'(req.data.resend_interval);
								ram_wdata.retries  = req.data.retry_budget;
								ram_wdata.conn     = req.data.conn_handle;
								push               = 1'b1;
							end
						end
						REQ_ACK: begin
							state_d   = ST_ACK_SCAN;
							scan_wait = 1'b1;
						end
						REQ_TICK: state_d = ST_TICK_HEAD;
						REQ_NONE: state_d = ST_IDLE;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_ACK_SCAN: begin
				if (after_unlink_q) begin
					state_d = ST_ACK_SCAN;
				end else if (pos_q >= count) begin
					state_d = ST_EMIT;
					res_set = 1'b1;
				end else if (item_q.ack_id != 8'd0 && ram_rdata.id == item_q.ack_id
						&& ram_rdata.id != 8'd0 && pos_q != count_t'(QUEUE_DEPTH)) begin
					pop_start = 1'b1;
					free_en   = 1'b1;
					state_d   = ST_UNLINK;
				end else begin
					scan_wait = 1'b1;
				end
			end
			ST_UNLINK: begin
				if (!list_busy) begin
					if (requeue_q) begin
						push      = 1'b1;
						push_slot = cur_slot_q;
					end
					if (req_t'(item_q.req_type) == REQ_ACK) begin
						state_d = ST_EMIT;
						res_set = 1'b1;
					end else begin
						state_d = ST_TICK_HEAD;
					end
				end
			end
			ST_TICK_HEAD: state_d = ST_TICK_DECIDE;
			ST_TICK_DECIDE: begin
				if (tick_stop) begin
					state_d = res_held_q ? ST_EMIT : ST_IDLE;
					res_set = res_held_q;
				end else if (res_held_q) begin
					state_d = ST_EMIT;
					res_set = 1'b1;
				end else begin
					ram_we    = 1'b1;
					ram_waddr = rd_slot;
					if (ram_rdata.retries != 8'd0) begin
						ram_wdata.retries  = ram_rdata.retries - 8'd1;
						ram_wdata.deadline = ram_rdata.deadline
							+ time_t'(ram_rdata.interval);
					end
					pop_start = 1'b1;
					free_en   = (ram_rdata.retries == 8'd0);
					state_d   = ST_UNLINK;
				end
			end
			ST_EMIT: begin
				if (!res_valid_q || res.ready) begin
					state_d = (item_q.req_type == REQ_TICK && !res_q.last) ?
						ST_TICK_HEAD : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			now_q          <= '0;
			next_id_q      <= 8'd1;
			pos_q          <= '0;
			budget_q       <= '0;
			res_valid_q    <= 1'b0;
			res_held_q     <= 1'b0;
			after_unlink_q <= 1'b0;
			requeue_q      <= 1'b0;
			cur_slot_q     <= '0;
		end else begin
			state_q        <= state_d;
			after_unlink_q <= scan_wait;
			if (res_set) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					pos_q <= '0;
					if (req_take) begin
						item_q <= req.data;
						if (req.data.req_type == REQ_ADD) begin
							res_q.last  <= 1'b1;
							res_q.found <= 1'b0;
							if (count < count_t'(QUEUE_DEPTH)) begin
								res_q.kind       <= KIND_ADDED;
								res_q.entry_id   <= next_id_q;
								res_q.out_buffer <= req.data.buffer_handle;
								res_q.out_size   <= req.data.payload_size;
								res_q.out_conn   <= req.data.conn_handle;
								next_id_q <= (next_id_q == 8'hFF) ? 8'd1 : next_id_q + 8'd1;
							end else begin
								res_q.kind       <= KIND_FULL;
								res_q.entry_id   <= 8'd0;
								res_q.out_buffer <= '0;
								res_q.out_size   <= '0;
								res_q.out_conn   <= '0;
							end
						end else if (req.data.req_type == REQ_ACK) begin
							res_q.kind       <= KIND_REMOVED;
							res_q.entry_id   <= 8'd0;
							res_q.out_buffer <= '0;
							res_q.out_size   <= '0;
							res_q.out_conn   <= '0;
							res_q.found      <= 1'b0;
							res_q.last       <= 1'b1;
						end else if (req.data.req_type == REQ_TICK) begin
							now_q      <= now_q + time_t'(1);
							budget_q   <= (count > count_t'(MAX_RESULTS)) ?
								BUD_BITS'(MAX_RESULTS) : BUD_BITS'(count);
							res_q.last <= 1'b0;
							res_held_q <= 1'b0;
						end
					end
				end
				ST_ACK_SCAN: begin
					if (pop_start) begin
						requeue_q        <= 1'b0;
						res_q.entry_id   <= ram_rdata.id;
						res_q.out_buffer <= ram_rdata.buffer;
						res_q.out_size   <= ram_rdata.size;
						res_q.out_conn   <= ram_rdata.conn;
						res_q.found      <= 1'b1;
					end else if (scan_wait) begin
						pos_q <= pos_q + count_t'(1);
					end
				end
				ST_UNLINK: ;
				ST_TICK_HEAD: pos_q <= '0;
				ST_TICK_DECIDE: begin
					if (state_d == ST_UNLINK) begin
						budget_q         <= budget_q - 1'b1;
						cur_slot_q       <= rd_slot;
						requeue_q        <= (ram_rdata.retries != 8'd0);
						res_held_q       <= 1'b1;
						res_q.kind       <= (ram_rdata.retries != 8'd0) ?
							KIND_RESEND : KIND_GIVE_UP;
						res_q.entry_id   <= ram_rdata.id;
						res_q.out_buffer <= ram_rdata.buffer;
						res_q.out_size   <= ram_rdata.size;
						res_q.out_conn   <= ram_rdata.conn;
						res_q.found      <= 1'b0;
						res_q.last       <= 1'b0;
					end else if (res_set) begin
						res_held_q <= 1'b0;
						if (tick_stop) begin
							res_q.last <= 1'b1;
						end
					end
				end
				ST_EMIT: begin
					if (!res_valid_q || res.ready) begin
						pos_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// File: design/rtq_checker.sv
// ----------------------------------------------------------------------------
// Retransmit timer queue port checker
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
module rtq_port_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic res_valid,
	input logic res_ready,
	input logic [2:0] res_kind,
	input logic [7:0] res_entry_id,
	input logic res_found
);
	import rtq_pkg::*;

	a_no_accept_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !req_ready)
		else $error("Request accepted while a result waits.");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_kind))
		else $error("Result dropped before it was taken.");

	a_found_id: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_found |-> res_entry_id != 8'd0 && res_kind == KIND_REMOVED)
		else $error("Matched acknowledge carries no id.");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_kind <= KIND_GIVE_UP)
		else $error("Result kind out of range.");

endmodule

bind retransmit_timer_queue rtq_port_checker u_rtq_port_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.res_kind     (res.data.kind),
	.res_entry_id (res.data.entry_id),
	.res_found    (res.data.found)
);

// File: tb/rtq_checker.sv
// ----------------------------------------------------------------------------
// Retransmit timer queue checker
// Watches the request and result channels, keeps its own copy of the queue,
// predicts the results of each accepted request and compares them in order.
// ----------------------------------------------------------------------------
module rtq_checker (
	input  logic        clk,
	input  logic        arst_n,
	rtq_req_if.monitor  req_mon,
	rtq_res_if.monitor  res_mon,
	output int          fail_count,
	output int          pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import rtq_pkg::*;

	slot_t     q_slot [QUEUE_DEPTH];
	slot_idx_t q_order [$];
	logic [7:0] q_next_id;
	time_t      q_now;
	res_item_t  awaited_results [$];

	function automatic res_item_t make_result(kind_t k, logic [7:0] id, slot_t s, logic f);
		res_item_t r;
		r.kind = k;
		r.entry_id = id;
		r.out_buffer = s.buffer;
		r.out_size = s.size;
		r.out_conn = s.conn;
		r.found = f;
		r.last = 1'b0;
		return r;
	endfunction

	task automatic predict_request(req_item_t it);
		res_item_t   batch [$];
		slot_t       s;
		slot_t       blank;
		int          budget;
		int          free_idx;
		bit          used;
		bit          hit;
		time_t       diff;
		slot_idx_t   h;
		blank = '0;
		case (req_t'(it.req_type))
			REQ_ADD: begin
				if (q_order.size() >= QUEUE_DEPTH) begin
					batch.push_back(make_result(KIND_FULL, 8'd0, blank, 1'b0));
				end else begin
					free_idx = 0;
					for (int c = 0; c < QUEUE_DEPTH; c++) begin
						used = 0;
						foreach (q_order[i]) if (q_order[i] == c) used = 1;
						if (!used) begin
							free_idx = c;
							break;
						end
					end
					s.id = q_next_id;
					s.buffer = it.buffer_handle;
					s.size = it.payload_size;
					s.interval = it.resend_interval;
					s.deadline = q_now + time_t'(it.resend_interval);
					s.retries = it.retry_budget;
					s.conn = it.conn_handle;
					q_slot[free_idx] = s;
					q_order.push_back(slot_idx_t'(free_idx));
					q_next_id = q_next_id + 8'd1;
					if (q_next_id == 8'd0) q_next_id = 8'd1;
					batch.push_back(make_result(KIND_ADDED, s.id, s, 1'b0));
				end
			end
			REQ_ACK: begin
				hit = 0;
				foreach (q_order[i]) begin
					if (!hit && it.ack_id != 8'd0 && q_slot[q_order[i]].id == it.ack_id) begin
						batch.push_back(make_result(KIND_REMOVED, it.ack_id,
							q_slot[q_order[i]], 1'b1));
						q_order.delete(i);
						hit = 1;
						break;
					end
				end
				if (!hit) batch.push_back(make_result(KIND_REMOVED, 8'd0, blank, 1'b0));
			end
			REQ_TICK: begin
				q_now = q_now + time_t'(1);
				budget = (q_order.size() > MAX_RESULTS) ? MAX_RESULTS : q_order.size();
				for (int k = 0; k < budget && q_order.size() > 0; k++) begin
					h = q_order[0];
					diff = q_now - q_slot[h].deadline;
					if (diff[TIME_BITS-1]) break;
					void'(q_order.pop_front());
					if (q_slot[h].retries == 8'd0) begin
						batch.push_back(make_result(KIND_GIVE_UP, q_slot[h].id, q_slot[h], 1'b0));
					end else begin
						batch.push_back(make_result(KIND_RESEND, q_slot[h].id, q_slot[h], 1'b0));
						q_slot[h].retries = q_slot[h].retries - 8'd1;
						q_slot[h].deadline = q_slot[h].deadline + time_t'(q_slot[h].interval);
						q_order.push_back(h);
					end
				end
			end
			default: ;
		endcase
		if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
		foreach (batch[i]) awaited_results.push_back(batch[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_item_t want;
		res_item_t got;
		if (!arst_n) begin
			q_order.delete();
			awaited_results.delete();
			q_next_id = 8'd1;
			q_now = '0;
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			if (res_mon.valid && res_mon.ready) begin
				got = res_mon.data;
				if (awaited_results.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("Unexpected result: %p", got);
				end else begin
					want = awaited_results.pop_front();
					if (got.kind !== want.kind || got.entry_id !== want.entry_id ||
						got.out_buffer !== want.out_buffer ||
						got.out_size !== want.out_size ||
						got.out_conn !== want.out_conn || got.found !== want.found ||
						got.last !== want.last) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("Mismatch: expected %p, actual %p", want, got);
					end
				end
			end
			if (req_mon.valid && req_mon.ready) predict_request(req_mon.data);
			pending_count <= awaited_results.size();
		end
	end

endmodule

// File: tb/tb_retransmit_timer_queue.sv
// ----------------------------------------------------------------------------
// Retransmit timer queue testbench
// Drives directed and random add, acknowledge, tick and none requests with varied
// idling on both channels and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_retransmit_timer_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import rtq_pkg::*;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending_count;
	int   send_idle_pct;
	int   recv_stall_pct;
	int   hold_cycles;
	logic [7:0] recent_ids [$];

	rtq_req_if req_ch ();
	rtq_res_if res_ch ();

	retransmit_timer_queue DUT (.clk(clk), .arst_n(arst_n), .req(req_ch), .res(res_ch));

	rtq_checker checker_inst (
		.clk(clk), .arst_n(arst_n), .req_mon(req_ch), .res_mon(res_ch),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

	// The receiver stalls at random, or for a fixed stretch when one is asked for.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (res_ch.valid && res_ch.ready && res_ch.data.kind == KIND_ADDED)
			recent_ids.push_back(res_ch.data.entry_id);
		if (recent_ids.size() > 32) void'(recent_ids.pop_front());
	end

	task automatic send_request(req_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= it;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	task automatic stop_sending();
		req_ch.valid <= 1'b0;
	endtask

	function automatic req_item_t make_request(req_t r, logic [7:0] id, logic [15:0] buf_h,
		logic [15:0] sz, logic [15:0] tmo, logic [7:0] rt, logic [7:0] cn);
		req_item_t it;
		it.req_type = r;
		it.ack_id = id;
		it.buffer_handle = buf_h;
		it.payload_size = sz;
		it.resend_interval = tmo;
		it.retry_budget = rt;
		it.conn_handle = cn;
		return it;
	endfunction

	function automatic req_item_t random_request();
		int sel;
		logic [7:0] id;
		logic [15:0] tmo;
		logic [7:0] rt;
		sel = $urandom_range(99);
		id = 8'($urandom_range(255));
		if (recent_ids.size() > 0 && $urandom_range(3) != 0)
			id = recent_ids[$urandom_range(recent_ids.size()-1)];
		tmo = ($urandom_range(9) == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(6));
		rt = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
		if (sel < 40)
			return make_request(REQ_ADD, 8'($urandom_range(255)), 16'($urandom_range(65535)),
				16'($urandom_range(65535)), tmo, rt, 8'($urandom_range(255)));
		else if (sel < 65)
			return make_request(REQ_ACK, id, 16'($urandom_range(65535)),
				16'($urandom_range(65535)), 16'($urandom_range(65535)),
				8'($urandom_range(255)), 8'($urandom_range(255)));
		else if (sel < 97)
			return make_request(REQ_TICK, 8'($urandom_range(255)), 16'($urandom_range(65535)),
				16'($urandom_range(65535)), 16'($urandom_range(65535)),
				8'($urandom_range(255)), 8'($urandom_range(255)));
		else
			return make_request(REQ_NONE, 8'($urandom_range(255)), 16'($urandom_range(65535)),
				16'($urandom_range(65535)), 16'($urandom_range(65535)),
				8'($urandom_range(255)), 8'($urandom_range(255)));
	endfunction

	task automatic drain_results();
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		res_ch.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: field extremes, zero timeout, full queue, misses and give-up.
		send_request(make_request(REQ_ADD, 8'd0, 16'hFFFF, 16'hFFFF, 16'd0, 8'd0, 8'hFF));
		send_request(make_request(REQ_ADD, 8'hFF, 16'h0000, 16'h0000, 16'hFFFF, 8'hFF, 8'h00));
		send_request(make_request(REQ_TICK, 8'd0, 16'd0, 16'd0, 16'd1, 8'd0, 8'd0));
		send_request(make_request(REQ_ACK, 8'd0, 16'd0, 16'd0, 16'd1, 8'd0, 8'd0));
		send_request(make_request(REQ_ACK, 8'd2, 16'd0, 16'd0, 16'd1, 8'd0, 8'd0));
		send_request(make_request(REQ_ACK, 8'd2, 16'd0, 16'd0, 16'd1, 8'd0, 8'd0));
		send_request(make_request(REQ_NONE, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
		for (int i = 0; i < 17; i++)
			send_request(make_request(REQ_ADD, 8'd0, 16'(i), 16'(i * 3), 16'(1 + i % 2),
				8'(i % 3), 8'(i)));
		repeat (3) send_request(make_request(REQ_TICK, 8'd0, 16'd0, 16'd0, 16'd1, 8'd0, 8'd0));
		stop_sending();
		drain_results();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 20 : 67) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 20 : 67) : 0;
			if (ph == 2) hold_cycles <= 600;
			for (int n = 0; n < 100; n++) send_request(random_request());
			// Pause here until every result so far has come back.
			if (ph == 1) begin
				stop_sending();
				drain_results();
			end
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int n = 0; n < 20; n++)
			send_request(make_request(REQ_TICK, 8'd0, 16'd0, 16'd0, 16'd1, 8'd0, 8'd0));
		stop_sending();

		drain_results();
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
